@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent assertions with a fixed error report
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define SRPP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("srpp checker: assertion failed");

// checked on every edge, reset included
`define SRPP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("srpp checker: assertion failed");

`endif

@@ sv/srpp_pkg.sv @@
// ----------------------------------------------------------------------------
// srpp_pkg
// types, codes and the microcode table of the serial register packet parser
// ----------------------------------------------------------------------------
package srpp_pkg;

  localparam logic [7:0] CODE_READ      = 8'h52;
  localparam logic [7:0] CODE_WRITE     = 8'h57;
  localparam logic [7:0] HEADER_RESET   = 8'hA6;
  localparam logic [7:0] PING_RESET     = 8'hB0;
  localparam logic [7:0] RESERVED_RESET = 8'h07;

  // configuration register indexes
  localparam logic [7:0] CFG_HEADER   = 8'd0;
  localparam logic [7:0] CFG_PING     = 8'd1;
  localparam logic [7:0] CFG_RESERVED = 8'd2;

  typedef enum logic [2:0] {
    ST_HEADER, ST_RW, ST_ADDR, ST_COUNT, ST_DATA, ST_CHECK, ST_PRIME, ST_EMIT
  } step_t;

  typedef enum logic [2:0] {
    OP_HEADER, OP_RW, OP_ADDR, OP_COUNT, OP_DATA, OP_CHECK, OP_PRIME, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_HDR_MATCH, C_RW_OK, C_TO_DATA, C_DATA_END, C_BURST, C_LAST_OUT
  } cond_t;

  typedef enum logic [3:0] {
    K_ACCEPT  = 4'd0,
    K_PING    = 4'd1,
    K_BADHDR  = 4'd2,
    K_BADRW   = 4'd3,
    K_BADSUM  = 4'd4,
    K_WRITE   = 4'd5,
    K_READ    = 4'd6,
    K_COMMAND = 4'd7,
    K_TOOLONG = 4'd8
  } kind_t;

  // one microcode word: take waits for a received word, emit waits for a
  // free result slot, jump is taken when the selected condition holds
  typedef struct packed {
    logic  take;
    logic  emit;
    op_t   op;
    cond_t cond;
    step_t jump;
    step_t fall;
  } ctrl_t;

  typedef struct packed {
    logic go;
    logic hdr_match;
    logic rw_ok;
    logic to_data;
    logic data_end;
    logic burst;
    logic last_out;
  } flags_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] ping_byte;
    logic [7:0] reserved_address;
  } cfg_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    unique case (s)
      ST_HEADER: w = '{take: 1'b1, emit: 1'b0, op: OP_HEADER, cond: C_HDR_MATCH,
                       jump: ST_RW, fall: ST_HEADER};
      ST_RW:     w = '{take: 1'b1, emit: 1'b0, op: OP_RW, cond: C_RW_OK,
                       jump: ST_ADDR, fall: ST_HEADER};
      ST_ADDR:   w = '{take: 1'b1, emit: 1'b0, op: OP_ADDR, cond: C_ALWAYS,
                       jump: ST_COUNT, fall: ST_COUNT};
      ST_COUNT:  w = '{take: 1'b1, emit: 1'b0, op: OP_COUNT, cond: C_TO_DATA,
                       jump: ST_DATA, fall: ST_CHECK};
      ST_DATA:   w = '{take: 1'b1, emit: 1'b0, op: OP_DATA, cond: C_DATA_END,
                       jump: ST_CHECK, fall: ST_DATA};
      ST_CHECK:  w = '{take: 1'b1, emit: 1'b0, op: OP_CHECK, cond: C_BURST,
                       jump: ST_PRIME, fall: ST_HEADER};
      ST_PRIME:  w = '{take: 1'b0, emit: 1'b0, op: OP_PRIME, cond: C_ALWAYS,
                       jump: ST_EMIT, fall: ST_EMIT};
      ST_EMIT:   w = '{take: 1'b0, emit: 1'b1, op: OP_EMIT, cond: C_LAST_OUT,
                       jump: ST_HEADER, fall: ST_EMIT};
      default:   w = '{take: 1'b1, emit: 1'b0, op: OP_HEADER, cond: C_HDR_MATCH,
                       jump: ST_RW, fall: ST_HEADER};
    endcase
    return w;
  endfunction

endpackage

@@ sv/srpp_ram.sv @@
// ----------------------------------------------------------------------------
// srpp_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module srpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/srpp_seq.sv @@
// ----------------------------------------------------------------------------
// srpp_seq
// step counter and microcode table lookup with conditional jumps
// ----------------------------------------------------------------------------
module srpp_seq (
  input  logic              clk,
  input  logic              rst,
  input  srpp_pkg::flags_t  flags,
  output srpp_pkg::ctrl_t   ctrl
);

  srpp_pkg::step_t step;
  srpp_pkg::step_t step_next;
  logic            cond_met;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= srpp_pkg::ST_HEADER;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = srpp_pkg::ucode(step);
    unique case (ctrl.cond)
      srpp_pkg::C_ALWAYS:    cond_met = 1'b1;
      srpp_pkg::C_HDR_MATCH: cond_met = flags.hdr_match;
      srpp_pkg::C_RW_OK:     cond_met = flags.rw_ok;
      srpp_pkg::C_TO_DATA:   cond_met = flags.to_data;
      srpp_pkg::C_DATA_END:  cond_met = flags.data_end;
      srpp_pkg::C_BURST:     cond_met = flags.burst;
      srpp_pkg::C_LAST_OUT:  cond_met = flags.last_out;
      default:               cond_met = 1'b0;
    endcase
    step_next = step;
    if (flags.go) begin
      step_next = cond_met ? ctrl.jump : ctrl.fall;
    end
  end

endmodule

@@ sv/srpp_dp.sv @@
// ----------------------------------------------------------------------------
// srpp_dp
// frame datapath: checksum, frame fields, payload buffer and result register
// ----------------------------------------------------------------------------
module srpp_dp #(
  parameter int PAYLOAD_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  srpp_pkg::ctrl_t   ctrl,
  input  srpp_pkg::cfg_t    cfg,
  output srpp_pkg::flags_t  flags,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        kind,
  output logic [7:0]        reg_address,
  output logic [7:0]        reg_data,
  output logic [7:0]        byte_count,
  output logic              last
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

  logic          is_write;
  logic [7:0]    running_sum;
  logic [7:0]    frame_address;
  logic [7:0]    frame_count;
  logic [7:0]    bytes_left;
  logic [CW-1:0] store_index;
  logic [7:0]    first_byte;
  logic [AW-1:0] emit_index;

  logic          slot_free;
  logic          go;
  logic [7:0]    sum_in;
  logic          sum_ok;
  logic          store_room;
  logic          fits;

  logic          res_load;
  srpp_pkg::kind_t res_kind;
  logic [7:0]    res_address;
  logic [7:0]    res_data;
  logic [7:0]    res_count;
  logic          res_last;

  logic          ram_wr_en;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;

  srpp_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_payload (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (store_index[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    slot_free  = !out_valid || out_ready;
    in_ready   = ctrl.take && slot_free;
    go         = ctrl.take ? (in_valid && in_ready) : (ctrl.emit ? slot_free : 1'b1);
    sum_in     = running_sum + rx_byte;
    sum_ok     = (sum_in == 8'd0);
    store_room = (store_index < CW'(PAYLOAD_DEPTH));
    fits       = (frame_count <= 8'(PAYLOAD_DEPTH));

    flags.go        = go;
    flags.hdr_match = (rx_byte == cfg.header_byte);
    flags.rw_ok     = (rx_byte == srpp_pkg::CODE_READ) || (rx_byte == srpp_pkg::CODE_WRITE);
    flags.to_data   = is_write && (rx_byte != 8'd0);
    flags.data_end  = (bytes_left == 8'd1);
    flags.burst     = sum_ok && is_write && fits && (frame_count != 8'd0)
                      && (frame_address != cfg.reserved_address);
    flags.last_out  = (8'(emit_index) == frame_count - 8'd1);

    ram_wr_en   = go && (ctrl.op == srpp_pkg::OP_DATA) && store_room;
    ram_rd_en   = go && ((ctrl.op == srpp_pkg::OP_PRIME) || (ctrl.op == srpp_pkg::OP_EMIT));
    ram_rd_addr = (ctrl.op == srpp_pkg::OP_PRIME) ? '0 : emit_index + AW'(1);

    res_load    = 1'b1;
    res_kind    = srpp_pkg::K_ACCEPT;
    res_address = 8'd0;
    res_data    = 8'd0;
    res_count   = 8'd0;
    res_last    = 1'b1;
    unique case (ctrl.op)
      srpp_pkg::OP_HEADER: begin
        if (flags.hdr_match) begin
          res_kind = srpp_pkg::K_ACCEPT;
        end else if (rx_byte == cfg.ping_byte) begin
          res_kind = srpp_pkg::K_PING;
        end else begin
          res_kind = srpp_pkg::K_BADHDR;
        end
      end
      srpp_pkg::OP_RW: begin
        res_kind = flags.rw_ok ? srpp_pkg::K_ACCEPT : srpp_pkg::K_BADRW;
      end
      srpp_pkg::OP_ADDR, srpp_pkg::OP_COUNT, srpp_pkg::OP_DATA: begin
        res_kind = srpp_pkg::K_ACCEPT;
      end
      srpp_pkg::OP_CHECK: begin
        priority if (!sum_ok) begin
          res_kind = srpp_pkg::K_BADSUM;
        end else if (!is_write) begin
          res_kind    = srpp_pkg::K_READ;
          res_address = frame_address;
          res_count   = frame_count;
        end else if (!fits) begin
          res_kind    = srpp_pkg::K_TOOLONG;
          res_address = frame_address;
          res_count   = frame_count;
        end else if (frame_address == cfg.reserved_address) begin
          res_kind    = srpp_pkg::K_COMMAND;
          res_address = frame_address;
          res_data    = (frame_count != 8'd0) ? first_byte : 8'd0;
          res_count   = frame_count;
        end else if (frame_count == 8'd0) begin
          res_kind    = srpp_pkg::K_ACCEPT;
          res_address = frame_address;
        end else begin
          // good write burst: results come from the emit steps
          res_load = 1'b0;
        end
      end
      srpp_pkg::OP_PRIME: begin
        res_load = 1'b0;
      end
      srpp_pkg::OP_EMIT: begin
        res_kind    = srpp_pkg::K_WRITE;
        res_address = frame_address + 8'(emit_index);
        res_data    = ram_rd_data;
        res_last    = flags.last_out;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
    res_load = res_load && go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      kind        <= res_kind;
      reg_address <= res_address;
      reg_data    <= res_data;
      byte_count  <= res_count;
      last        <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      unique case (ctrl.op)
        srpp_pkg::OP_HEADER: begin
          if (flags.hdr_match) begin
            running_sum <= rx_byte;
          end
        end
        srpp_pkg::OP_RW: begin
          if (flags.rw_ok) begin
            is_write    <= (rx_byte == srpp_pkg::CODE_WRITE);
            running_sum <= sum_in;
          end
        end
        srpp_pkg::OP_ADDR: begin
          frame_address <= rx_byte;
          running_sum   <= sum_in;
        end
        srpp_pkg::OP_COUNT: begin
          frame_count <= rx_byte;
          bytes_left  <= rx_byte;
          store_index <= '0;
          running_sum <= sum_in;
        end
        srpp_pkg::OP_DATA: begin
          running_sum <= sum_in;
          bytes_left  <= bytes_left - 8'd1;
          if (store_room) begin
            store_index <= store_index + CW'(1);
          end
          // keep the first payload word for reserved-address commands
          if (store_index == '0) begin
            first_byte <= rx_byte;
          end
        end
        srpp_pkg::OP_PRIME: begin
          emit_index <= '0;
        end
        srpp_pkg::OP_EMIT: begin
          emit_index <= emit_index + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/serial_register_packet_parser.sv @@
// ----------------------------------------------------------------------------
// serial_register_packet_parser
// command frame parser for a byte-wide serial receive stream
// ----------------------------------------------------------------------------
// Takes one received word per cycle while parsing a frame (header, read/write
// code, address, count, payload, checksum) and gives one result per word from
// the result register in the cycle after the word is accepted; a word is only
// taken while the result register is free or being emptied in that cycle.
// After a good write frame with payload to an ordinary address it stops taking
// words while it starts reading the payload buffer, then gives one register
// write result per cycle while the result side does not stall, paced by the
// single read port of the payload memory. Control is a microcode table of
// eight steps walked by a step counter. Configuration writes are always taken
// (cfg_ready stays high).
// ----------------------------------------------------------------------------
module serial_register_packet_parser #(
  parameter int PAYLOAD_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] kind,
  output logic [7:0] reg_address,
  output logic [7:0] reg_data,
  output logic [7:0] byte_count,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  srpp_pkg::cfg_t   cfg;
  srpp_pkg::ctrl_t  ctrl;
  srpp_pkg::flags_t flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte      <= srpp_pkg::HEADER_RESET;
      cfg.ping_byte        <= srpp_pkg::PING_RESET;
      cfg.reserved_address <= srpp_pkg::RESERVED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srpp_pkg::CFG_HEADER:   cfg.header_byte      <= cfg_data;
        srpp_pkg::CFG_PING:     cfg.ping_byte        <= cfg_data;
        srpp_pkg::CFG_RESERVED: cfg.reserved_address <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  srpp_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  srpp_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cfg         (cfg),
    .flags       (flags),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .reg_address (reg_address),
    .reg_data    (reg_data),
    .byte_count  (byte_count),
    .last        (last)
  );

endmodule

@@ sv/srpp_checker.sv @@
// ----------------------------------------------------------------------------
// srpp_checker
// port-level checks of the packet parser, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srpp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] kind,
  input logic [7:0] reg_address,
  input logic [7:0] reg_data,
  input logic       last
);

  // a waiting result holds still until it is taken
  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(reg_address)
                                && $stable(reg_data);
  endproperty

  // result codes stay in the defined set
  `SRPP_ASSERT(a_kind_range, clk, rst, out_valid |-> kind <= srpp_pkg::K_TOOLONG)

  // only register write bursts carry more than one result per word
  `SRPP_ASSERT(a_single_last, clk, rst, out_valid && kind != srpp_pkg::K_WRITE |-> last)

  // a word is only taken when its result has somewhere to go
  `SRPP_ASSERT_ALWAYS(a_no_take_on_full, clk, in_valid && in_ready |-> !out_valid || out_ready)

  `SRPP_ASSERT(a_out_hold, clk, rst, p_out_hold)

endmodule

bind serial_register_packet_parser srpp_checker u_srpp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .reg_address (reg_address),
  .reg_data    (reg_data),
  .last        (last)
);

@@ bench/serial_register_packet_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_register_packet_parser_tb
// Sends received words to the frame parser, first from a short directed table
// and then as random frames, broken frames and noise under several register
// settings. Every result is compared field by field with its table entry or
// the output of a bench frame parser model, with random stalls on both sides.
// ----------------------------------------------------------------------------
module serial_register_packet_parser_tb;

  localparam int PAYLOAD_DEPTH = 16;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_WORDS   = 38;

  typedef struct packed {
    srpp_pkg::kind_t kind;
    logic [7:0]      addr;
    logic [7:0]      data;
    logic [7:0]      count;
    logic            last;
  } parse_result_t;

  typedef struct packed {
    logic [7:0]    word;
    logic          typed;
    parse_result_t res;
  } script_row_t;

  localparam parse_result_t NO_RESULT = '0;

  // typed rows carry the result the word must give, the rest use the model
  localparam script_row_t SCRIPT [26] = '{
    '{8'h00, 1'b1, '{srpp_pkg::K_BADHDR, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{8'hB0, 1'b1, '{srpp_pkg::K_PING, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{8'hA6, 1'b1, '{srpp_pkg::K_ACCEPT, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{8'h00, 1'b1, '{srpp_pkg::K_BADRW, 8'h00, 8'h00, 8'h00, 1'b1}},
    // read of 255 bytes at the top address
    '{8'hA6, 1'b0, NO_RESULT},
    '{8'h52, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h0A, 1'b1, '{srpp_pkg::K_READ, 8'hFF, 8'h00, 8'hFF, 1'b1}},
    // write with no payload goes straight to the checksum
    '{8'hA6, 1'b0, NO_RESULT},
    '{8'h57, 1'b0, NO_RESULT},
    '{8'h10, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hF3, 1'b0, NO_RESULT},
    // read with a wrong checksum
    '{8'hA6, 1'b0, NO_RESULT},
    '{8'h52, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{srpp_pkg::K_BADSUM, 8'h00, 8'h00, 8'h00, 1'b1}},
    // two register writes, address wraps past 0xff
    '{8'hA6, 1'b0, NO_RESULT},
    '{8'h57, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'h11, 1'b0, NO_RESULT},
    '{8'h22, 1'b0, NO_RESULT},
    '{8'hCF, 1'b0, NO_RESULT}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] kind;
  logic [7:0] reg_address;
  logic [7:0] reg_data;
  logic [7:0] byte_count;
  logic       last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_data = 8'h00;

  serial_register_packet_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .reg_address(reg_address),
    .reg_data   (reg_data),
    .byte_count (byte_count),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // parser model state and its copy of the registers
  logic [7:0]      cfg_header = srpp_pkg::HEADER_RESET;
  logic [7:0]      cfg_ping = srpp_pkg::PING_RESET;
  logic [7:0]      cfg_reserved = srpp_pkg::RESERVED_RESET;
  srpp_pkg::step_t ph = srpp_pkg::ST_HEADER;
  logic            frame_is_write = 1'b0;
  logic [7:0]      frame_addr = 8'h00;
  logic [7:0]      frame_cnt = 8'h00;
  logic [7:0]      remaining = 8'h00;
  logic [7:0]      csum = 8'h00;
  logic [7:0]      payload [PAYLOAD_DEPTH];
  int              fill = 0;

  parse_result_t word_results [$];
  parse_result_t pending_results [$];
  parse_result_t seen_want;

  int   failures = 0;
  int   results_checked = 0;
  int   words_sent = 0;
  int   cfg_writes = 0;
  int   settings_used = 1;
  int   quiet_cycles = 0;
  bit   src_steady = 1'b0;
  bit   sink_steady = 1'b0;
  bit   hold_request = 1'b0;
  bit   hold_asked = 1'b0;

  function automatic void add_result(input srpp_pkg::kind_t k, input logic [7:0] a,
                                     input logic [7:0] d, input logic [7:0] c,
                                     input logic l);
    parse_result_t r;
    r = '{k, a, d, c, l};
    word_results.push_back(r);
  endfunction

  // one received word through the frame parser; results land in word_results
  function automatic void parse_word(input logic [7:0] b);
    logic [7:0] want_sum;
    logic [7:0] off;
    int n;
    int i;
    word_results.delete();
    case (ph)
      srpp_pkg::ST_RW: begin
        if (b == srpp_pkg::CODE_READ || b == srpp_pkg::CODE_WRITE) begin
          frame_is_write = (b == srpp_pkg::CODE_WRITE);
          csum = csum + b;
          ph = srpp_pkg::ST_ADDR;
          add_result(srpp_pkg::K_ACCEPT, 8'h00, 8'h00, 8'h00, 1'b1);
        end else begin
          ph = srpp_pkg::ST_HEADER;
          add_result(srpp_pkg::K_BADRW, 8'h00, 8'h00, 8'h00, 1'b1);
        end
      end
      srpp_pkg::ST_ADDR: begin
        frame_addr = b;
        csum = csum + b;
        ph = srpp_pkg::ST_COUNT;
        add_result(srpp_pkg::K_ACCEPT, 8'h00, 8'h00, 8'h00, 1'b1);
      end
      srpp_pkg::ST_COUNT: begin
        frame_cnt = b;
        csum = csum + b;
        remaining = b;
        fill = 0;
        ph = (frame_is_write && b != 8'h00) ? srpp_pkg::ST_DATA : srpp_pkg::ST_CHECK;
        add_result(srpp_pkg::K_ACCEPT, 8'h00, 8'h00, 8'h00, 1'b1);
      end
      srpp_pkg::ST_DATA: begin
        // words past the buffer still count toward the checksum
        if (fill < PAYLOAD_DEPTH) begin
          payload[fill] = b;
          fill++;
        end
        csum = csum + b;
        remaining = remaining - 8'd1;
        if (remaining == 8'h00) ph = srpp_pkg::ST_CHECK;
        add_result(srpp_pkg::K_ACCEPT, 8'h00, 8'h00, 8'h00, 1'b1);
      end
      srpp_pkg::ST_CHECK: begin
        want_sum = 8'h00 - csum;
        ph = srpp_pkg::ST_HEADER;
        if (b != want_sum) begin
          add_result(srpp_pkg::K_BADSUM, 8'h00, 8'h00, 8'h00, 1'b1);
        end else if (!frame_is_write) begin
          add_result(srpp_pkg::K_READ, frame_addr, 8'h00, frame_cnt, 1'b1);
        end else if (frame_cnt > PAYLOAD_DEPTH) begin
          add_result(srpp_pkg::K_TOOLONG, frame_addr, 8'h00, frame_cnt, 1'b1);
        end else if (frame_addr == cfg_reserved) begin
          add_result(srpp_pkg::K_COMMAND, frame_addr,
                     (frame_cnt != 8'h00) ? payload[0] : 8'h00, frame_cnt, 1'b1);
        end else if (frame_cnt == 8'h00) begin
          add_result(srpp_pkg::K_ACCEPT, frame_addr, 8'h00, 8'h00, 1'b1);
        end else begin
          n = int'(frame_cnt);
          for (i = 0; i < n; i++) begin
            off = i[7:0];
            add_result(srpp_pkg::K_WRITE, frame_addr + off, payload[i], 8'h00, i == n - 1);
          end
        end
      end
      default: begin
        // header match wins over the ping byte
        if (b == cfg_header) begin
          csum = b;
          ph = srpp_pkg::ST_RW;
          add_result(srpp_pkg::K_ACCEPT, 8'h00, 8'h00, 8'h00, 1'b1);
        end else if (b == cfg_ping) begin
          ph = srpp_pkg::ST_HEADER;
          add_result(srpp_pkg::K_PING, 8'h00, 8'h00, 8'h00, 1'b1);
        end else begin
          ph = srpp_pkg::ST_HEADER;
          add_result(srpp_pkg::K_BADHDR, 8'h00, 8'h00, 8'h00, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    failures++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %02h want %02h",
                                results_checked, name, got, want));
  endtask

  // valid stays up across back-to-back words, it only drops for a gap
  task automatic send_word(input logic [7:0] b, input logic typed,
                           input parse_result_t typed_res);
    int gap;
    gap = (src_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    parse_word(b);
    if (typed) pending_results.push_back(typed_res);
    else foreach (word_results[i]) pending_results.push_back(word_results[i]);
  endtask

  task automatic send_frame();
    logic [7:0] bytes_q [$];
    logic [7:0] sum;
    logic [7:0] cnt;
    logic [7:0] addr;
    logic [7:0] code;
    int r;
    int n;
    r = $urandom_range(0, 99);
    src_steady = ($urandom_range(0, 3) == 0);
    if (r < 70) begin
      code = ($urandom_range(0, 2) != 0) ? srpp_pkg::CODE_WRITE : srpp_pkg::CODE_READ;
      n = $urandom_range(0, 9);
      addr = (n < 3) ? cfg_reserved : (n < 5) ? 8'($urandom_range(240, 255)) : 8'($urandom);
      if (code == srpp_pkg::CODE_READ) begin
        cnt = 8'($urandom);
      end else begin
        n = $urandom_range(0, 15);
        cnt = (n == 0) ? 8'h00 :
              (n < 3)  ? 8'($urandom_range(17, 24)) :
              (n < 6)  ? 8'($urandom_range(1, 16)) : 8'($urandom_range(1, 4));
      end
      bytes_q = '{cfg_header, code, addr, cnt};
      if (code == srpp_pkg::CODE_WRITE) repeat (cnt) bytes_q.push_back(8'($urandom));
      sum = 8'h00;
      foreach (bytes_q[i]) sum = sum + bytes_q[i];
      sum = 8'h00 - sum;
      if ($urandom_range(0, 6) == 0) sum = sum ^ 8'($urandom_range(1, 255));
      bytes_q.push_back(sum);
    end else if (r < 77) begin
      bytes_q.push_back(8'($urandom));
    end else if (r < 83) begin
      bytes_q.push_back(cfg_ping);
    end else if (r < 90) begin
      code = 8'($urandom);
      while (code == srpp_pkg::CODE_READ || code == srpp_pkg::CODE_WRITE) code = 8'($urandom);
      bytes_q = '{cfg_header, code};
    end else begin
      // frame cut short inside its payload
      cnt = 8'($urandom_range(2, 8));
      bytes_q = '{cfg_header, srpp_pkg::CODE_WRITE, 8'($urandom), cnt};
      repeat ($urandom_range(0, cnt - 1)) bytes_q.push_back(8'($urandom));
    end
    foreach (bytes_q[i]) send_word(bytes_q[i], 1'b0, NO_RESULT);
  endtask

  task automatic run_random(input int n, input bit with_hold);
    int start;
    start = words_sent;
    while (words_sent - start < n) begin
      if (with_hold && !hold_asked && words_sent - start >= 15) begin
        hold_asked = 1'b1;
        hold_request = 1'b1;
      end
      send_frame();
    end
  endtask

  // stop sending and let every pending result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      srpp_pkg::CFG_HEADER:   cfg_header = val;
      srpp_pkg::CFG_PING:     cfg_ping = val;
      srpp_pkg::CFG_RESERVED: cfg_reserved = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] hdr, input logic [7:0] png,
                                input logic [7:0] rsv, input logic [7:0] stray_idx,
                                input logic [7:0] stray_val);
    settle();
    write_cfg(srpp_pkg::CFG_HEADER, hdr);
    write_cfg(srpp_pkg::CFG_PING, png);
    write_cfg(srpp_pkg::CFG_RESERVED, rsv);
    write_cfg(stray_idx, stray_val);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d addr %02h data %02h",
                                  kind, reg_address, reg_data));
      end else begin
        seen_want = pending_results.pop_front();
        check_field("kind", {4'h0, kind}, {4'h0, seen_want.kind});
        check_field("reg_address", reg_address, seen_want.addr);
        check_field("reg_data", reg_data, seen_want.data);
        check_field("byte_count", byte_count, seen_want.count);
        check_field("last", {7'h00, last}, {7'h00, seen_want.last});
      end
      results_checked++;
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without a handshake", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 47) == 0) sink_steady = !sink_steady;
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    logic [7:0] v;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(SCRIPT); i++)
      send_word(SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].res);
    run_random(PHASE_WORDS, 1'b0);

    apply_settings(8'h00, 8'hFF, 8'h00, 8'd3, 8'($urandom));
    run_random(PHASE_WORDS, 1'b0);

    apply_settings(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    run_random(PHASE_WORDS, 1'b1);

    // header and ping byte equal
    v = 8'($urandom);
    apply_settings(v, v, 8'($urandom), 8'($urandom_range(3, 255)), 8'($urandom));
    run_random(PHASE_WORDS, 1'b0);

    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(3, 255)),
                   8'($urandom));
    run_random(PHASE_WORDS, 1'b0);

    settle();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("summary: %0d words parsed under %0d register settings, %0d results checked",
             words_sent, settings_used, results_checked);
    $display("summary: %0d config writes, long output hold-off of %0d cycles, %0d mismatches",
             cfg_writes, HOLD_CYCLES, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ serial_register_packet_parser.f @@
+incdir+sv
sv/srpp_pkg.sv
sv/srpp_ram.sv
sv/srpp_seq.sv
sv/srpp_dp.sv
sv/serial_register_packet_parser.sv
sv/srpp_checker.sv
bench/serial_register_packet_parser_tb.sv
